FILE: src/swt_pkg.sv
`default_nettype none

package swt_pkg;

  // Report kinds
  localparam logic [1:0] ACT_PARSE_OK  = 2'd0;
  localparam logic [1:0] ACT_PARSE_ERR = 2'd1;
  localparam logic [1:0] ACT_GEOM_SET  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MARGIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSING    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_HEIGHT = 3'd5;
  localparam int unsigned CFG_DATA_W = 12;

  // Counter limits
  localparam logic [7:0] COUNT_MAX       = 8'd255;
  localparam logic [7:0] GAIN_AGE_LIMIT  = 8'd100;
  localparam logic [7:0] RESET_AGE_LIMIT = 8'd25;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        top_row;
    logic [11:0]        bottom_row;
    logic [11:0]        crop_start;
    logic [11:0]        crop_rows;
    logic               gain_hint_valid;
    logic signed [15:0] gain_hint;
    logic               no_surface;
    logic               history_present;
  } report_t;

  typedef struct packed {
    logic               set_window;
    logic [11:0]        req_offset;
    logic [12:0]        req_height;
    logic               apply_gain;
    logic signed [15:0] gain_out;
    logic               reset_window_gain;
  } result_t;

  typedef struct packed {
    logic [9:0]  edge_margin;
    logic [11:0] min_window_height;
    logic [9:0]  drift_limit;
    logic [7:0]  max_missing_frames;
    logic [11:0] default_offset;
    logic [11:0] default_height;
  } cfg_t;

endpackage

`default_nettype wire

FILE: src/swt_stream_if.sv
`default_nettype none

interface swt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: src/swt_core.sv
`default_nettype none

module swt_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [swt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           step,
  input  wire swt_pkg::report_t               rpt,
  output swt_pkg::result_t                    res
);
  import swt_pkg::*;

  cfg_t cfg;

  logic        pending_valid, pending_valid_next;
  logic [11:0] pending_offset, pending_offset_next;
  logic [12:0] pending_height, pending_height_next;
  logic [7:0]  missing_count, missing_count_next;
  logic [7:0]  gain_age, gain_age_next;

  // Signed working copies (16 bits cover every sum and difference below)
  logic signed [15:0] top_s, bot_s, off_s, h_s, wm_s, mm_s, minh_s;
  logic signed [15:0] top_dev, bot_dev, span, nh0, short_gap, bot_edge;
  logic               reduced_ok, move, short_win, dims_ok, changed;
  logic [11:0]        no0, adj, no_f;
  logic [12:0]        nh_f;
  logic [7:0]         age_inc, miss_inc, miss_err;
  logic               too_many, do_reset;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_margin        <= 10'd32;
      cfg.min_window_height  <= 12'd256;
      cfg.drift_limit        <= 10'd16;
      cfg.max_missing_frames <= 8'd10;
      cfg.default_offset     <= 12'd0;
      cfg.default_height     <= 12'd4095;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EDGE_MARGIN:    cfg.edge_margin        <= cfg_data[9:0];
        CFG_MIN_HEIGHT:     cfg.min_window_height  <= cfg_data[11:0];
        CFG_DRIFT_LIMIT:    cfg.drift_limit        <= cfg_data[9:0];
        CFG_MAX_MISSING:    cfg.max_missing_frames <= cfg_data[7:0];
        CFG_DEFAULT_OFFSET: cfg.default_offset     <= cfg_data[11:0];
        CFG_DEFAULT_HEIGHT: cfg.default_height     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Window geometry
  always_comb begin
    top_s  = $signed({4'd0, rpt.top_row});
    bot_s  = $signed({4'd0, rpt.bottom_row});
    off_s  = $signed({4'd0, rpt.crop_start});
    h_s    = $signed({4'd0, rpt.crop_rows});
    wm_s   = $signed({6'd0, cfg.edge_margin});
    mm_s   = $signed({6'd0, cfg.drift_limit});
    minh_s = $signed({4'd0, cfg.min_window_height});

    dims_ok = !pending_valid ||
              (pending_offset == rpt.crop_start &&
               pending_height == {1'b0, rpt.crop_rows});

    span     = bot_s - top_s + (wm_s <<< 1);
    bot_edge = off_s + h_s;
    reduced_ok = (rpt.crop_rows == cfg.min_window_height) && (span <= minh_s) &&
                 (off_s + wm_s <= top_s) && (bot_s + wm_s <= bot_edge);

    top_dev = top_s - wm_s - off_s;
    bot_dev = bot_s + wm_s - bot_edge;
    move = !reduced_ok &&
           ((top_dev > mm_s) || (-top_dev > mm_s) ||
            (bot_dev > mm_s) || (-bot_dev > mm_s));

    // Proposed window, widened symmetrically up to the minimum height
    no0 = (top_s > wm_s) ? 12'(top_s - wm_s) : 12'd0;
    nh0 = bot_s - $signed({4'd0, no0}) + wm_s;
    short_win = nh0 < minh_s;
    short_gap = minh_s - nh0;
    adj  = short_gap[12:1];
    no_f = short_win ? ((no0 > adj) ? (no0 - adj) : 12'd0) : no0;
    nh_f = short_win ? {1'b0, cfg.min_window_height} : nh0[12:0];
    changed = (no_f != rpt.crop_start) || (nh_f != {1'b0, rpt.crop_rows});
  end

  // Counters and next state
  always_comb begin
    age_inc  = (gain_age == COUNT_MAX) ? gain_age : gain_age + 8'd1;
    miss_inc = (missing_count == COUNT_MAX) ? missing_count : missing_count + 8'd1;
    miss_err = rpt.no_surface ? miss_inc : 8'd0;
    too_many = miss_err == cfg.max_missing_frames;
    do_reset = !rpt.history_present &&
               ((!pending_valid && rpt.crop_start != 12'd0 &&
                 gain_age > RESET_AGE_LIMIT) || too_many);

    pending_valid_next  = pending_valid;
    pending_offset_next = pending_offset;
    pending_height_next = pending_height;
    missing_count_next  = missing_count;
    gain_age_next       = gain_age;
    res                 = '0;

    case (rpt.action)
      ACT_PARSE_OK: begin
        missing_count_next = 8'd0;
        if (dims_ok) begin
          if (move) begin
            if (changed) begin
              pending_valid_next  = 1'b1;
              pending_offset_next = no_f;
              pending_height_next = nh_f;
              res.set_window      = 1'b1;
              res.req_offset      = no_f;
              res.req_height      = nh_f;
            end
          end else begin
            pending_valid_next = 1'b0;
          end
        end
        gain_age_next = age_inc;
        if (age_inc > GAIN_AGE_LIMIT && rpt.gain_hint_valid) begin
          res.apply_gain = 1'b1;
          res.gain_out   = rpt.gain_hint;
          gain_age_next  = 8'd0;
        end
      end
      ACT_PARSE_ERR: begin
        missing_count_next = miss_err;
        if (do_reset) begin
          res.reset_window_gain = 1'b1;
          pending_valid_next    = 1'b1;
          pending_offset_next   = cfg.default_offset;
          pending_height_next   = {1'b0, cfg.default_height};
        end
      end
      ACT_GEOM_SET: begin
        pending_valid_next = 1'b0;
      end
      default: ;
    endcase
  end

  // Commit state on each processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid  <= 1'b0;
      pending_offset <= 12'd0;
      pending_height <= 13'd0;
      missing_count  <= 8'd0;
      gain_age       <= 8'd0;
    end else if (step) begin
      pending_valid  <= pending_valid_next;
      pending_offset <= pending_offset_next;
      pending_height <= pending_height_next;
      missing_count  <= missing_count_next;
      gain_age       <= gain_age_next;
    end
  end

  a_set_makes_pending: assert property (@(posedge clk) disable iff (rst)
    step && res.set_window |=> pending_valid && pending_height == $past(res.req_height))
    else $error("set_window without matching pending request");

  a_reset_loads_defaults: assert property (@(posedge clk) disable iff (rst)
    step && res.reset_window_gain |=>
      pending_valid && pending_offset == $past(cfg.default_offset))
    else $error("window reset did not load default offset");

  a_gain_age_clears: assert property (@(posedge clk) disable iff (rst)
    step && res.apply_gain |=> gain_age == 8'd0)
    else $error("gain age not cleared after gain change");

endmodule

`default_nettype wire

FILE: src/sensor_window_tracker.sv
`default_nettype none

// Channel  Dir  Payload                                     Handshake
// report   in   swt_pkg::report_t (one frame report)        valid/ready
// result   out  swt_pkg::result_t (window/gain requests)    valid/ready
// cfg      in   cfg_we, cfg_index (3b), cfg_data (12b)      write on cfg_we
//
// One request per cycle sustained while result.ready holds; a result is offered
// after its request passes the input register, then the result register.
// The tracking state updates as a request moves from the input register to
// the result register, so back-to-back requests see each other's effects.
// A stalled result holds both registers; report.ready drops only when both
// are full. Synchronous active-high reset restores configuration defaults.

module sensor_window_tracker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  swt_stream_if.sink                          report,
  swt_stream_if.source                        result,
  input  wire logic                           cfg_we,
  input  wire logic [swt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import swt_pkg::*;

  logic    s1_valid;
  report_t s1_rpt;
  logic    out_valid;
  result_t out_res;
  result_t core_res;
  logic    advance;

  // Move the held request into the result register when it is free
  assign advance      = s1_valid && (!out_valid || result.ready);
  assign report.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (report.ready) begin
      s1_valid <= report.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (report.valid && report.ready) begin
      s1_rpt <= report.payload;
    end
  end

  swt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .rpt       (s1_rpt),
    .res       (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_res;

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !result.ready |-> !report.ready)
    else $error("request accepted while both stages are stalled");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a held request");

  a_set_or_reset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.set_window && out_res.reset_window_gain))
    else $error("window set and window reset in one result");

endmodule

`default_nettype wire
